// File: hw/rtl/pcbe_pkg.sv
// shared types and constants for the piecewise cubic bezier evaluator
package pcbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CP_W      = 20;
    localparam int INT_W     = CP_W - FRAC_BITS;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 5;
    localparam int PT_W      = 32;
    localparam int U_W       = FRAC_BITS + 1;
    localparam int SQ_W      = 2 * U_W;
    localparam int U3_W      = U_W + 2;
    localparam int WT_W      = 3 * FRAC_BITS + 1;
    localparam int WLO_W     = 24;
    localparam int WHI_W     = WT_W - WLO_W;
    localparam int PL_W      = WLO_W + 1 + PT_W;
    localparam int PH_W      = WHI_W + 1 + PT_W;
    localparam int ACC_W     = WT_W + PT_W + 3;
    localparam int RES_LSB   = 3 * FRAC_BITS;

    localparam logic [U_W-1:0]   U_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] RND_HALF =
        {{(ACC_W - RES_LSB){1'b0}}, 1'b1, {(RES_LSB - 1){1'b0}}};

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [IDX_W-1:0]       point_index;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic [CP_W-1:0]        curve_param;
    } pcbe_in_t;

    typedef struct packed {
        logic signed [PT_W-1:0] curve_x;
        logic signed [PT_W-1:0] curve_y;
    } pcbe_out_t;

    typedef struct packed {
        logic mul;
        logic term;
        logic pair;
        logic fin;
    } pcbe_adv_t;

endpackage

// File: hw/rtl/pcbe_coord.sv
// weighted sum of four control coordinates with rounding, four pipeline stages
module pcbe_coord import pcbe_pkg::*; (
    input  logic                         aclk,
    input  pcbe_adv_t                    adv,
    input  logic [3:0][WT_W-1:0]         weight,
    input  logic [3:0][PT_W-1:0]         point,
    output logic signed [PT_W-1:0]       coord_reg
);

    logic signed [PL_W-1:0]  pl_reg [4];
    logic signed [PH_W-1:0]  ph_reg [4];
    logic signed [ACC_W-1:0] term_reg [4];
    logic signed [ACC_W-1:0] term_next [4];
    logic signed [ACC_W-1:0] s01_reg;
    logic signed [ACC_W-1:0] s23_reg;
    logic signed [ACC_W-1:0] acc_next;

    // split weight into low and high parts to keep multipliers narrow
    always_ff @(posedge aclk) begin
        if (adv.mul) begin
            for (int k = 0; k < 4; k++) begin
                pl_reg[k] <= $signed({1'b0, weight[k][WLO_W-1:0]}) * $signed(point[k]);
                ph_reg[k] <= $signed({1'b0, weight[k][WT_W-1:WLO_W]}) * $signed(point[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            term_next[k] = (ACC_W'(ph_reg[k]) <<< WLO_W) + ACC_W'(pl_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.term) begin
            for (int k = 0; k < 4; k++) begin
                term_reg[k] <= term_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.pair) begin
            s01_reg <= term_reg[0] + term_reg[1];
            s23_reg <= term_reg[2] + term_reg[3] + $signed(RND_HALF);
        end
    end

    assign acc_next = s01_reg + s23_reg;

    always_ff @(posedge aclk) begin
        if (adv.fin) begin
            coord_reg <= acc_next[RES_LSB+PT_W-1:RES_LSB];
        end
    end

endmodule

// File: hw/rtl/piecewise_cubic_bezier_eval_core.sv
// top level of the piecewise cubic bezier path evaluator
//
// s_ channel carries one item per handshake: a load writes one control
// point (slot = segment * 4 + point number), an evaluate carries the curve
// parameter t with 16 fraction bits. loads give no result; each evaluate
// gives one item on the m_ channel with the x and y of the curve point.
// cfg_we/cfg_wdata write the segment count; write it only while idle.
// an evaluate's result passes through the seven register stages (table
// read, weight squares, weight cubes, partial products, term assembly,
// pair sums, final sum and rounding); one item is accepted every cycle
// while m_ready does not stall the pipeline.
// control points live in four banks, one per point number, each read once
// per evaluate at the edge that accepts it; a load writes only its point's bank.
// reset clears all valid bits and sets the segment count to 1; the point
// table is not cleared and must be loaded before use.
// when m_ready is low, items stay in place, the pipeline fills behind the
// output register and s_ready drops once every stage holds an item.
module piecewise_cubic_bezier_eval_core import pcbe_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pcbe_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pcbe_out_t        m_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [CNT_W-1:0] cfg_count_reg;
    logic [CNT_W-1:0] cnt_eff;
    logic             eop;
    logic [INT_W-1:0] seg;
    logic [U_W-1:0]   u0;
    logic [SEG_W-1:0] rd_row;
    logic [SEG_W-1:0] wr_row;
    logic             accept;
    logic             rd_en;
    logic             wr_en;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg, vld7_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

    logic [U_W-1:0]        u1_reg, v1_reg;
    logic [2*PT_W-1:0]     pts1_reg [4];
    logic [SQ_W-1:0]       uu2_reg, vv2_reg;
    logic [U_W-1:0]        u2_reg, v2_reg;
    logic [U3_W-1:0]       u3_2_reg, v3_2_reg;
    logic [2*PT_W-1:0]     pts2_reg [4];
    logic [3:0][WT_W-1:0]  w3_reg;
    logic [2*PT_W-1:0]     pts3_reg [4];
    logic [3:0][PT_W-1:0]  px3, py3;
    pcbe_adv_t             adv;
    logic signed [PT_W-1:0] cx_reg, cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= CNT_W'(1);
        end else if (cfg_we) begin
            cfg_count_reg <= cfg_wdata;
        end
    end

    // clamp count, then split t into segment and local parameter
    always_comb begin
        if (cfg_count_reg == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (int'(cfg_count_reg) > MAX_SEGMENTS) begin
            cnt_eff = CNT_W'(MAX_SEGMENTS);
        end else begin
            cnt_eff = cfg_count_reg;
        end
        eop = s_data.curve_param >= CP_W'({cnt_eff, {FRAC_BITS{1'b0}}});
        if (eop) begin
            seg = INT_W'(cnt_eff - CNT_W'(1));
            u0  = U_ONE;
        end else begin
            seg = s_data.curve_param[CP_W-1:FRAC_BITS];
            u0  = {1'b0, s_data.curve_param[FRAC_BITS-1:0]};
        end
    end

    assign adv7 = !vld7_reg || m_ready;
    assign adv6 = !vld6_reg || adv7;
    assign adv5 = !vld5_reg || adv6;
    assign adv4 = !vld4_reg || adv5;
    assign adv3 = !vld3_reg || adv4;
    assign adv2 = !vld2_reg || adv3;
    assign adv1 = !vld1_reg || adv2;
    assign s_ready = adv1;

    assign accept = s_valid && s_ready;
    assign rd_en  = accept && s_data.action == ACT_EVAL;
    assign wr_en  = accept && s_data.action == ACT_LOAD
                    && int'(s_data.point_index) < 4 * MAX_SEGMENTS;
    assign rd_row = SEG_W'(seg);
    assign wr_row = SEG_W'(s_data.point_index[IDX_W-1:2]);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [2*PT_W-1:0] mem [MAX_SEGMENTS];

        always_ff @(posedge aclk) begin
            if (wr_en && s_data.point_index[1:0] == 2'(b)) begin
                mem[wr_row] <= {s_data.point_x, s_data.point_y};
            end
            if (rd_en) begin
                pts1_reg[b] <= mem[rd_row];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
        end else begin
            if (adv1) vld1_reg <= s_valid && s_data.action == ACT_EVAL;
            if (adv2) vld2_reg <= vld1_reg;
            if (adv3) vld3_reg <= vld2_reg;
            if (adv4) vld4_reg <= vld3_reg;
            if (adv5) vld5_reg <= vld4_reg;
            if (adv6) vld6_reg <= vld5_reg;
            if (adv7) vld7_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            u1_reg <= u0;
            v1_reg <= U_ONE - u0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            uu2_reg  <= u1_reg * u1_reg;
            vv2_reg  <= v1_reg * v1_reg;
            u2_reg   <= u1_reg;
            v2_reg   <= v1_reg;
            u3_2_reg <= U3_W'(u1_reg) + (U3_W'(u1_reg) << 1);
            v3_2_reg <= U3_W'(v1_reg) + (U3_W'(v1_reg) << 1);
            for (int k = 0; k < 4; k++) begin
                pts2_reg[k] <= pts1_reg[k];
            end
        end
    end

    // bernstein weights v^3, 3v^2u, 3vu^2, u^3
    always_ff @(posedge aclk) begin
        if (adv3) begin
            w3_reg[0] <= WT_W'(vv2_reg) * v2_reg;
            w3_reg[1] <= WT_W'(vv2_reg) * u3_2_reg;
            w3_reg[2] <= WT_W'(uu2_reg) * v3_2_reg;
            w3_reg[3] <= WT_W'(uu2_reg) * u2_reg;
            for (int k = 0; k < 4; k++) begin
                pts3_reg[k] <= pts2_reg[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            px3[k] = pts3_reg[k][2*PT_W-1:PT_W];
            py3[k] = pts3_reg[k][PT_W-1:0];
        end
    end

    assign adv.mul  = adv4;
    assign adv.term = adv5;
    assign adv.pair = adv6;
    assign adv.fin  = adv7;

    pcbe_coord u_coord_x (
        .aclk      (aclk),
        .adv       (adv),
        .weight    (w3_reg),
        .point     (px3),
        .coord_reg (cx_reg)
    );

    pcbe_coord u_coord_y (
        .aclk      (aclk),
        .adv       (adv),
        .weight    (w3_reg),
        .point     (py3),
        .coord_reg (cy_reg)
    );

    assign m_valid        = vld7_reg;
    assign m_data.curve_x = cx_reg;
    assign m_data.curve_y = cy_reg;

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.action == ACT_LOAD) |=> !vld1_reg)
        else $error("load item entered the pipeline");

    a_eval_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.action == ACT_EVAL) |=> vld1_reg)
        else $error("evaluate item lost at entry");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld1_reg && vld2_reg && vld3_reg && vld4_reg && vld5_reg && vld6_reg
         && vld7_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld6_reg))
        else $error("result appeared without an item in the last stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the piecewise cubic bezier evaluator core
module tb_top import pcbe_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 32;
    localparam int MAX_SEG     = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    pcbe_in_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    pcbe_out_t        m_data;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    pcbe_in_t               pending[$];
    pcbe_out_t              curve_pts[$];
    logic signed [PT_W-1:0] x_tab[TABLE_SLOTS];
    logic signed [PT_W-1:0] y_tab[TABLE_SLOTS];
    logic [CNT_W-1:0]       seg_count = 4'd1;
    logic [TABLE_SLOTS-1:0] filled = '0;
    logic                   s_took = 1'b0;
    logic                   no_gaps = 1'b0;
    int                     cycles = 0;
    int                     n_loads = 0;
    int                     n_evals = 0;
    int                     n_points = 0;
    int                     n_errors = 0;
    int                     n_settings = 1;

    piecewise_cubic_bezier_eval_core #(.MAX_SEGMENTS(MAX_SEG)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int active_segments();
        if (seg_count == 0) return 1;
        if (seg_count > MAX_SEG) return MAX_SEG;
        return int'(seg_count);
    endfunction

    function automatic logic signed [PT_W-1:0] blend4(input logic signed [PT_W-1:0] p0,
            input logic signed [PT_W-1:0] p1, input logic signed [PT_W-1:0] p2,
            input logic signed [PT_W-1:0] p3, input logic [U_W-1:0] u);
        logic signed [127:0] uw;
        logic signed [127:0] vw;
        logic signed [127:0] acc;
        uw = 128'(u);
        vw = (128'sd1 <<< FRAC_BITS) - uw;
        acc = p0 * vw * vw * vw + 3 * p1 * vw * vw * uw
            + 3 * p2 * vw * uw * uw + p3 * uw * uw * uw;
        acc = acc + (128'sd1 <<< (3 * FRAC_BITS - 1));
        acc = acc >>> (3 * FRAC_BITS);
        return acc[PT_W-1:0];
    endfunction

    function automatic int segment_of(input logic [CP_W-1:0] t);
        int cnt;
        cnt = active_segments();
        if (t >= (cnt << FRAC_BITS)) return cnt - 1;
        return int'(t >> FRAC_BITS);
    endfunction

    function automatic pcbe_out_t curve_point(input logic [CP_W-1:0] t);
        int         seg;
        int         base;
        logic [U_W-1:0] u;
        pcbe_out_t  r;
        seg = segment_of(t);
        base = seg * 4;
        if (t >= (active_segments() << FRAC_BITS)) begin
            u = U_ONE;
        end else begin
            u = {1'b0, t[FRAC_BITS-1:0]};
        end
        r.curve_x = blend4(x_tab[base], x_tab[base+1], x_tab[base+2], x_tab[base+3], u);
        r.curve_y = blend4(y_tab[base], y_tab[base+1], y_tab[base+2], y_tab[base+3], u);
        return r;
    endfunction

    function automatic logic [PT_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic pcbe_in_t make_item(input logic act, input int slot,
            input logic [PT_W-1:0] px, input logic [PT_W-1:0] py,
            input logic [CP_W-1:0] t);
        pcbe_in_t it;
        it.action = act;
        it.point_index = IDX_W'(slot);
        it.point_x = px;
        it.point_y = py;
        it.curve_param = t;
        if (act == ACT_LOAD) filled[slot] = 1'b1;
        return it;
    endfunction

    task automatic queue_phase(input int n);
        int             cnt;
        int             seg;
        int             slot;
        logic [CP_W-1:0] t;
        cnt = active_segments();
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(99)) inside
                [0:44]:  t = CP_W'($urandom_range((cnt << FRAC_BITS) - 1));
                [45:59]: t = CP_W'($urandom_range(cnt - 1) << FRAC_BITS);
                [60:67]: t = CP_W'(cnt << FRAC_BITS);
                [68:77]: t = CP_W'(($urandom_range(cnt - 1) << FRAC_BITS) | 16'hFFFF);
                default: t = CP_W'($urandom);
            endcase
            seg = segment_of(t);
            if (filled[seg*4 +: 4] != 4'hF) begin
                slot = seg * 4;
                while (filled[slot]) slot++;
                pending.push_back(make_item(ACT_LOAD, slot, rand_coord(), rand_coord(),
                    CP_W'($urandom)));
            end else if ($urandom_range(99) < 40) begin
                if ($urandom_range(3) == 0) slot = $urandom_range(TABLE_SLOTS - 1);
                else slot = $urandom_range(cnt * 4 - 1);
                pending.push_back(make_item(ACT_LOAD, slot, rand_coord(), rand_coord(),
                    CP_W'($urandom)));
            end else begin
                pending.push_back(make_item(ACT_EVAL, $urandom_range(TABLE_SLOTS - 1),
                    $urandom, $urandom, t));
            end
        end
    endtask

    task automatic settle();
        while (pending.size() != 0 || s_valid || curve_pts.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] val);
        settle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        seg_count = val;
        n_settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // producer side: one item held until accepted
    always @(negedge aclk) begin : drive
        logic hold;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            hold = s_valid && !s_took;
            s_took = 1'b0;
            if (!hold && pending.size() != 0 && (no_gaps || $urandom_range(99) >= 24)) begin
                s_data <= pending.pop_front();
                hold = 1'b1;
            end
            s_valid <= hold;
            m_ready <= no_gaps || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin : watch
        pcbe_out_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d curve points outstanding", $time,
                curve_pts.size());
            $display("tb_top: FAIL");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                if (s_data.action == ACT_LOAD) begin
                    x_tab[s_data.point_index] = s_data.point_x;
                    y_tab[s_data.point_index] = s_data.point_y;
                    n_loads++;
                end else begin
                    curve_pts.push_back(curve_point(s_data.curve_param));
                    n_evals++;
                end
            end
            if (m_valid && m_ready) begin
                n_points++;
                if (curve_pts.size() == 0) begin
                    $display("%0t: unexpected item x=%h y=%h", $time,
                        m_data.curve_x, m_data.curve_y);
                    n_errors++;
                end else begin
                    want = curve_pts.pop_front();
                    if (m_data.curve_x !== want.curve_x) begin
                        $display("%0t: curve_x expected %h actual %h", $time,
                            want.curve_x, m_data.curve_x);
                        n_errors++;
                    end
                    if (m_data.curve_y !== want.curve_y) begin
                        $display("%0t: curve_y expected %h actual %h", $time,
                            want.curve_y, m_data.curve_y);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] settings[8];
        settings = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd1, 4'd6, 4'd2, 4'd0};
        settings[7] = CNT_W'($urandom_range(15));
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // segment count 1 from reset: extremes, ends of range, rounding of halves
        pending.push_back(make_item(ACT_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF));
        pending.push_back(make_item(ACT_LOAD, 1, 32'h8000_0000, 32'h7FFF_FFFF, 20'h0));
        pending.push_back(make_item(ACT_LOAD, 2, 32'h7FFF_FFFF, 32'h8000_0000, 20'h0));
        pending.push_back(make_item(ACT_LOAD, 3, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF));
        pending.push_back(make_item(ACT_EVAL, 31, '1, '1, 20'h0));
        pending.push_back(make_item(ACT_EVAL, 0, '0, '0, 20'h08000));
        pending.push_back(make_item(ACT_EVAL, 5, $urandom, $urandom, 20'h00001));
        pending.push_back(make_item(ACT_EVAL, 9, $urandom, $urandom, 20'h0FFFF));
        pending.push_back(make_item(ACT_EVAL, 0, $urandom, $urandom, 20'h10000));
        pending.push_back(make_item(ACT_EVAL, 31, '1, '1, 20'hFFFFF));
        pending.push_back(make_item(ACT_LOAD, 0, 32'd4, -32'sd4, 20'h0));
        pending.push_back(make_item(ACT_LOAD, 1, 32'd0, 32'd0, 20'h0));
        pending.push_back(make_item(ACT_LOAD, 2, 32'd0, 32'd0, 20'h0));
        pending.push_back(make_item(ACT_LOAD, 3, 32'd0, 32'd0, 20'h0));
        pending.push_back(make_item(ACT_EVAL, 0, '0, '0, 20'h08000));
        pending.push_back(make_item(ACT_LOAD, 31, 32'hFFFF_FFFF, 32'd1, 20'h12345));
        pending.push_back(make_item(ACT_EVAL, 0, '0, '0, 20'h80000));

        foreach (settings[p]) begin
            write_count(settings[p]);
            no_gaps = (p == 3);
            queue_phase(PHASE_ITEMS);
        end
        settle();
        no_gaps = 1'b0;

        if (curve_pts.size() != 0) begin
            $display("%0t: %0d curve points never arrived", $time, curve_pts.size());
            n_errors++;
        end
        $display("run covered %0d point loads and %0d evaluations over %0d count settings",
            n_loads, n_evals, n_settings);
        $display("%0d curve points checked, %0d mismatches", n_points, n_errors);
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
